/* hw/rtl/mean_baseline_rmse_evaluator_assert.svh */
// Assertion macros shared by the evaluator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MEAN_BASELINE_RMSE_EVALUATOR_ASSERT_SVH
`define MEAN_BASELINE_RMSE_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MBRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mbre assertion failed");

// next-cycle implication
`define MBRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mbre assertion failed");

`endif

/* hw/rtl/mbre_pkg.sv */
// Shared types and constants for the mean baseline RMSE evaluator.
// No dependencies.
package mbre_pkg;

    localparam int KIND_W   = 2;
    localparam int UID_W    = 10;
    localparam int MID_W    = 11;
    localparam int RAT_W    = 3;
    localparam int ENTRY_W  = UID_W + MID_W + RAT_W;
    localparam int RMSE_W   = 16;
    localparam int TCNT_W   = 16;
    localparam int STAT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int OUT_FRAC = 12;
    // scaled mean square is always below 2^30 (errors stay below 8.0)
    localparam int MS_W     = 30;
    localparam int RT_W     = MS_W / 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRAIN  = 2'd0,
        KIND_TEST   = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    localparam logic [MODE_W-1:0] MODE_GLOBAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_USER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOVIE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_TRAIN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_TEST  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd3;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRAIN_WR,
        ST_GDIV,
        ST_FB_RDT,
        ST_FB_RDM,
        ST_FB_ACC,
        ST_FB_END,
        ST_FB_DIV,
        ST_SEEN_CLR,
        ST_EV_RDT,
        ST_EV_RDM,
        ST_EV_PRED,
        ST_EV_DIV,
        ST_EV_DIFF,
        ST_EV_MUL,
        ST_EV_ACC,
        ST_MS_START,
        ST_MS_DIV,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic user_we;
        logic movie_we;
        logic seen_we;
        logic seen_val;
    } tbl_ctl_t;

endpackage

/* hw/rtl/mean_baseline_rmse_evaluator.sv */
// Mean-rating baseline predictor with RMSE report: top level and sequencer.
// Depends on mbre_pkg, mbre_div, mbre_isqrt, mbre_tables, mbre_tstore.
//
// Training beats are read, then the user and movie entries are written
// back; test beats and register writes need no extra state. A clear beat
// runs a clearing pass over max(USER_SLOTS, MOVIE_SLOTS) entries, and the
// same pass runs after reset before the first beat is accepted.
// A finish beat with N buffered tests divides out the global mean; in mode 2
// it then walks the tests for the fallback, does one more divide and sweeps
// the MOVIE_SLOTS marks. Each test is then read and predicted, with a divide
// when its user (mode 1) or movie (mode 2) has ratings, and its squared error
// is summed; then the mean square is divided out and its root taken.
// The divider is bit-serial and D bits wide (46 at defaults), and the test
// buffer has a single read port. The result beat sits in an output register,
// so new beats are taken while it waits.
`include "mean_baseline_rmse_evaluator_assert.svh"

module mean_baseline_rmse_evaluator #(
    parameter int USER_SLOTS  = 1024,
    parameter int MOVIE_SLOTS = 2048,
    parameter int TRAIN_MAX   = 131072,
    parameter int TEST_SLOTS  = 32768,
    parameter int FRAC_BITS   = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // user_id[9:0], movie_id[20:10], rating[23:21]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // rmse[15:0], tested_count[31:16]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata  // predict_mode[1:0]
);
    localparam int CNT_W   = $clog2(TRAIN_MAX + 1);
    localparam int SUM_W   = CNT_W + mbre_pkg::RAT_W;
    localparam int UA_W    = $clog2(USER_SLOTS);
    localparam int MA_W    = $clog2(MOVIE_SLOTS);
    localparam int TA_W    = $clog2(TEST_SLOTS);
    localparam int TF_W    = $clog2(TEST_SLOTS + 1);
    localparam int PRED_W  = mbre_pkg::RAT_W + FRAC_BITS;
    localparam int SQ_W    = 2 * PRED_W + TF_W;
    localparam int MDVD_W  = SUM_W + FRAC_BITS;
    localparam int DVD_W   = (MDVD_W > SQ_W) ? MDVD_W : SQ_W;
    localparam int DVS_W   = (CNT_W > TF_W) ? CNT_W : TF_W;
    localparam int CLR_N   = (USER_SLOTS > MOVIE_SLOTS) ? USER_SLOTS : MOVIE_SLOTS;
    localparam int CW      = $clog2(CLR_N);
    localparam int SH_R    = (2 * FRAC_BITS >= 2 * mbre_pkg::OUT_FRAC)
                           ? 2 * FRAC_BITS - 2 * mbre_pkg::OUT_FRAC : 0;
    localparam int SH_L    = (2 * FRAC_BITS >= 2 * mbre_pkg::OUT_FRAC)
                           ? 0 : 2 * mbre_pkg::OUT_FRAC - 2 * FRAC_BITS;
    localparam int WIDE_W  = DVD_W + SH_L;

    mbre_pkg::state_t state_reg, state_next;

    logic [mbre_pkg::MODE_W-1:0] mode_reg;
    logic [SUM_W-1:0]  gsum_reg;
    logic [CNT_W-1:0]  gcount_reg;
    logic [TF_W-1:0]   fill_reg;
    logic              ovf_reg;
    logic [CW-1:0]     clr_idx_reg;
    logic [TF_W-1:0]   idx_reg;
    logic [UA_W-1:0]   uaddr_reg;
    logic [MA_W-1:0]   maddr_reg;
    logic [mbre_pkg::RAT_W-1:0] rat_reg;
    logic [PRED_W-1:0] gmean_reg;
    logic [PRED_W-1:0] fb_reg;
    logic [PRED_W-1:0] pred_reg;
    logic [PRED_W-1:0] diff_reg;
    logic [2*PRED_W-1:0] sq_reg;
    logic [SQ_W-1:0]   sq_sum_reg;
    logic [SUM_W-1:0]  fs_reg;
    logic [CNT_W-1:0]  fc_reg;
    logic [mbre_pkg::RMSE_W-1:0] res_rmse_reg;
    logic [mbre_pkg::TCNT_W-1:0] res_cnt_reg;
    logic [mbre_pkg::STAT_W-1:0] res_stat_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    // input beat decode
    mbre_pkg::kind_t            in_kind;
    logic [mbre_pkg::UID_W-1:0] in_uid;
    logic [mbre_pkg::MID_W-1:0] in_mid;
    logic [mbre_pkg::RAT_W-1:0] in_rat;
    logic s_acc, id_bad, train_ok, test_ok;

    assign in_kind = mbre_pkg::kind_t'(s_tuser);
    assign in_uid  = s_tdata[9:0];
    assign in_mid  = s_tdata[20:10];
    assign in_rat  = s_tdata[23:21];
    assign s_acc   = s_tvalid && s_tready;
    assign id_bad  = (32'(in_uid) >= USER_SLOTS) || (32'(in_mid) >= MOVIE_SLOTS);
    assign train_ok = !id_bad && (32'(gcount_reg) < TRAIN_MAX);
    assign test_ok  = !id_bad && (32'(fill_reg) < TEST_SLOTS);

    // memories and arithmetic units
    mbre_pkg::tbl_ctl_t tctl;
    logic [UA_W-1:0]  t_uaddr;
    logic [MA_W-1:0]  t_maddr;
    logic [SUM_W-1:0] t_usum_wr, t_msum_wr, u_sum_rd, m_sum_rd;
    logic [CNT_W-1:0] t_ucnt_wr, t_mcnt_wr, u_cnt_rd, m_cnt_rd;
    logic             seen_rd;

    logic                         ts_we;
    logic [mbre_pkg::ENTRY_W-1:0] ts_wdata, ts_rdata;
    logic [mbre_pkg::RAT_W-1:0]   te_rat;
    logic [mbre_pkg::MID_W-1:0]   te_mid;
    logic [mbre_pkg::UID_W-1:0]   te_uid;

    logic             div_start, div_busy, div_done;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic             sqrt_start, sqrt_done;
    logic [WIDE_W-1:0] ms_wide;
    logic [mbre_pkg::MS_W-1:0] ms_val;
    logic [mbre_pkg::RT_W-1:0] sqrt_root;

    logic [TF_W-1:0]   idx_inc;
    logic              idx_last, use_div;
    logic [PRED_W-1:0] actual;

    assign te_rat   = ts_rdata[2:0];
    assign te_mid   = ts_rdata[13:3];
    assign te_uid   = ts_rdata[23:14];
    assign idx_inc  = idx_reg + TF_W'(1);
    assign idx_last = (idx_inc == fill_reg);
    assign use_div  = ((mode_reg == mbre_pkg::MODE_USER) && (u_cnt_rd != '0))
                   || ((mode_reg == mbre_pkg::MODE_MOVIE) && (m_cnt_rd != '0));
    assign actual   = {rat_reg, {FRAC_BITS{1'b0}}};
    assign ms_wide  = WIDE_W'(div_q) >> SH_R << SH_L;
    assign ms_val   = ms_wide[mbre_pkg::MS_W-1:0];

    mbre_tables #(
        .USER_SLOTS (USER_SLOTS),
        .MOVIE_SLOTS(MOVIE_SLOTS),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W),
        .UA_W       (UA_W),
        .MA_W       (MA_W)
    ) u_tables (
        .aclk    (aclk),
        .ctl     (tctl),
        .u_addr  (t_uaddr),
        .m_addr  (t_maddr),
        .u_sum_wr(t_usum_wr),
        .u_cnt_wr(t_ucnt_wr),
        .m_sum_wr(t_msum_wr),
        .m_cnt_wr(t_mcnt_wr),
        .u_sum_rd(u_sum_rd),
        .u_cnt_rd(u_cnt_rd),
        .m_sum_rd(m_sum_rd),
        .m_cnt_rd(m_cnt_rd),
        .seen_rd (seen_rd)
    );

    mbre_tstore #(
        .TEST_SLOTS(TEST_SLOTS),
        .TA_W      (TA_W)
    ) u_tstore (
        .aclk   (aclk),
        .we     (ts_we),
        .wr_addr(fill_reg[TA_W-1:0]),
        .wr_data(ts_wdata),
        .rd_addr(idx_reg[TA_W-1:0]),
        .rd_data(ts_rdata)
    );

    mbre_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_q)
    );

    mbre_isqrt u_isqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sqrt_start),
        .value  (ms_val),
        .done   (sqrt_done),
        .root   (sqrt_root)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mbre_pkg::ST_CLEAR: begin
                if (clr_idx_reg == CW'(CLR_N - 1)) state_next = mbre_pkg::ST_IDLE;
            end
            mbre_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (in_kind)
                        mbre_pkg::KIND_TRAIN: begin
                            if (train_ok) state_next = mbre_pkg::ST_TRAIN_WR;
                        end
                        mbre_pkg::KIND_FINISH: begin
                            if (gcount_reg == '0 || fill_reg == '0) begin
                                state_next = mbre_pkg::ST_EMIT;
                            end else begin
                                state_next = mbre_pkg::ST_GDIV;
                            end
                        end
                        mbre_pkg::KIND_CLEAR: state_next = mbre_pkg::ST_CLEAR;
                        default: state_next = mbre_pkg::ST_IDLE;
                    endcase
                end
            end
            mbre_pkg::ST_TRAIN_WR: state_next = mbre_pkg::ST_IDLE;
            mbre_pkg::ST_GDIV: begin
                if (div_done) begin
                    state_next = (mode_reg == mbre_pkg::MODE_MOVIE)
                               ? mbre_pkg::ST_FB_RDT : mbre_pkg::ST_EV_RDT;
                end
            end
            mbre_pkg::ST_FB_RDT: state_next = mbre_pkg::ST_FB_RDM;
            mbre_pkg::ST_FB_RDM: state_next = mbre_pkg::ST_FB_ACC;
            mbre_pkg::ST_FB_ACC: begin
                state_next = idx_last ? mbre_pkg::ST_FB_END : mbre_pkg::ST_FB_RDT;
            end
            mbre_pkg::ST_FB_END: begin
                state_next = (fc_reg != '0) ? mbre_pkg::ST_FB_DIV : mbre_pkg::ST_SEEN_CLR;
            end
            mbre_pkg::ST_FB_DIV: begin
                if (div_done) state_next = mbre_pkg::ST_SEEN_CLR;
            end
            mbre_pkg::ST_SEEN_CLR: begin
                if (clr_idx_reg == CW'(MOVIE_SLOTS - 1)) state_next = mbre_pkg::ST_EV_RDT;
            end
            mbre_pkg::ST_EV_RDT: state_next = mbre_pkg::ST_EV_RDM;
            mbre_pkg::ST_EV_RDM: state_next = mbre_pkg::ST_EV_PRED;
            mbre_pkg::ST_EV_PRED: begin
                state_next = use_div ? mbre_pkg::ST_EV_DIV : mbre_pkg::ST_EV_DIFF;
            end
            mbre_pkg::ST_EV_DIV: begin
                if (div_done) state_next = mbre_pkg::ST_EV_DIFF;
            end
            mbre_pkg::ST_EV_DIFF: state_next = mbre_pkg::ST_EV_MUL;
            mbre_pkg::ST_EV_MUL:  state_next = mbre_pkg::ST_EV_ACC;
            mbre_pkg::ST_EV_ACC: begin
                state_next = idx_last ? mbre_pkg::ST_MS_START : mbre_pkg::ST_EV_RDT;
            end
            mbre_pkg::ST_MS_START: state_next = mbre_pkg::ST_MS_DIV;
            mbre_pkg::ST_MS_DIV: begin
                if (div_done) state_next = mbre_pkg::ST_SQRT;
            end
            mbre_pkg::ST_SQRT: begin
                if (sqrt_done) state_next = mbre_pkg::ST_EMIT;
            end
            mbre_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) state_next = mbre_pkg::ST_IDLE;
            end
            default: state_next = mbre_pkg::ST_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = (state_reg == mbre_pkg::ST_IDLE);
        tctl       = '0;
        t_uaddr    = uaddr_reg;
        t_maddr    = maddr_reg;
        t_usum_wr  = '0;
        t_ucnt_wr  = '0;
        t_msum_wr  = '0;
        t_mcnt_wr  = '0;
        ts_we      = 1'b0;
        ts_wdata   = {in_uid, in_mid, in_rat};
        div_start  = 1'b0;
        div_dvd    = DVD_W'(sq_sum_reg);
        div_dvs    = DVS_W'(fill_reg);
        sqrt_start = 1'b0;
        case (state_reg)
            mbre_pkg::ST_CLEAR: begin
                t_uaddr       = UA_W'(clr_idx_reg);
                t_maddr       = MA_W'(clr_idx_reg);
                tctl.user_we  = (32'(clr_idx_reg) < USER_SLOTS);
                tctl.movie_we = (32'(clr_idx_reg) < MOVIE_SLOTS);
                tctl.seen_we  = (32'(clr_idx_reg) < MOVIE_SLOTS);
            end
            mbre_pkg::ST_IDLE: begin
                t_uaddr = UA_W'(in_uid);
                t_maddr = MA_W'(in_mid);
                ts_we   = s_acc && (in_kind == mbre_pkg::KIND_TEST) && test_ok;
                if (s_acc && in_kind == mbre_pkg::KIND_FINISH
                        && gcount_reg != '0 && fill_reg != '0) begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({gsum_reg, {FRAC_BITS{1'b0}}});
                    div_dvs   = DVS_W'(gcount_reg);
                end
            end
            mbre_pkg::ST_TRAIN_WR: begin
                tctl.user_we  = 1'b1;
                tctl.movie_we = 1'b1;
                t_usum_wr     = u_sum_rd + SUM_W'(rat_reg);
                t_ucnt_wr     = u_cnt_rd + CNT_W'(1);
                t_msum_wr     = m_sum_rd + SUM_W'(rat_reg);
                t_mcnt_wr     = m_cnt_rd + CNT_W'(1);
            end
            mbre_pkg::ST_FB_RDM, mbre_pkg::ST_EV_RDM: begin
                t_uaddr = UA_W'(te_uid);
                t_maddr = MA_W'(te_mid);
            end
            mbre_pkg::ST_FB_ACC: begin
                // first sighting of this movie in the walk
                tctl.seen_we  = !seen_rd;
                tctl.seen_val = 1'b1;
            end
            mbre_pkg::ST_FB_END: begin
                div_start = (fc_reg != '0);
                div_dvd   = DVD_W'({fs_reg, {FRAC_BITS{1'b0}}});
                div_dvs   = DVS_W'(fc_reg);
            end
            mbre_pkg::ST_SEEN_CLR: begin
                t_maddr      = MA_W'(clr_idx_reg);
                tctl.seen_we = 1'b1;
            end
            mbre_pkg::ST_EV_PRED: begin
                div_start = use_div;
                if (mode_reg == mbre_pkg::MODE_USER) begin
                    div_dvd = DVD_W'({u_sum_rd, {FRAC_BITS{1'b0}}});
                    div_dvs = DVS_W'(u_cnt_rd);
                end else begin
                    div_dvd = DVD_W'({m_sum_rd, {FRAC_BITS{1'b0}}});
                    div_dvs = DVS_W'(m_cnt_rd);
                end
            end
            mbre_pkg::ST_MS_START: div_start = 1'b1;
            mbre_pkg::ST_MS_DIV:   sqrt_start = div_done;
            default: begin
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mbre_pkg::ST_CLEAR;
            mode_reg     <= mbre_pkg::MODE_GLOBAL;
            gsum_reg     <= '0;
            gcount_reg   <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) mode_reg <= cfg_wdata;
            // the emit state handles its own handoff
            if (m_tvalid_reg && m_tready && state_reg != mbre_pkg::ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                mbre_pkg::ST_CLEAR: clr_idx_reg <= clr_idx_reg + CW'(1);
                mbre_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        case (in_kind)
                            mbre_pkg::KIND_TRAIN: begin
                                if (train_ok) begin
                                    gsum_reg   <= gsum_reg + SUM_W'(in_rat);
                                    gcount_reg <= gcount_reg + CNT_W'(1);
                                    uaddr_reg  <= UA_W'(in_uid);
                                    maddr_reg  <= MA_W'(in_mid);
                                    rat_reg    <= in_rat;
                                end else begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            mbre_pkg::KIND_TEST: begin
                                if (test_ok) fill_reg <= fill_reg + TF_W'(1);
                                else         ovf_reg  <= 1'b1;
                            end
                            mbre_pkg::KIND_FINISH: begin
                                idx_reg      <= '0;
                                sq_sum_reg   <= '0;
                                fs_reg       <= '0;
                                fc_reg       <= '0;
                                clr_idx_reg  <= '0;
                                res_rmse_reg <= '0;
                                res_cnt_reg  <= '0;
                                res_stat_reg <= (gcount_reg == '0)
                                              ? mbre_pkg::STAT_NO_TRAIN : mbre_pkg::STAT_NO_TEST;
                            end
                            mbre_pkg::KIND_CLEAR: begin
                                gsum_reg    <= '0;
                                gcount_reg  <= '0;
                                fill_reg    <= '0;
                                ovf_reg     <= 1'b0;
                                clr_idx_reg <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                mbre_pkg::ST_GDIV: begin
                    if (div_done) begin
                        gmean_reg <= PRED_W'(div_q);
                        fb_reg    <= PRED_W'(div_q);
                    end
                end
                mbre_pkg::ST_FB_RDM: maddr_reg <= MA_W'(te_mid);
                mbre_pkg::ST_FB_ACC: begin
                    if (!seen_rd) begin
                        fs_reg <= fs_reg + m_sum_rd;
                        fc_reg <= fc_reg + m_cnt_rd;
                    end
                    idx_reg <= idx_inc;
                end
                mbre_pkg::ST_FB_DIV: begin
                    if (div_done) fb_reg <= PRED_W'(div_q);
                end
                mbre_pkg::ST_SEEN_CLR: begin
                    clr_idx_reg <= clr_idx_reg + CW'(1);
                    if (clr_idx_reg == CW'(MOVIE_SLOTS - 1)) idx_reg <= '0;
                end
                mbre_pkg::ST_EV_RDM: rat_reg <= te_rat;
                mbre_pkg::ST_EV_PRED: begin
                    // overwritten by the divider when the entry has ratings
                    pred_reg <= (mode_reg == mbre_pkg::MODE_MOVIE) ? fb_reg : gmean_reg;
                end
                mbre_pkg::ST_EV_DIV: begin
                    if (div_done) pred_reg <= PRED_W'(div_q);
                end
                mbre_pkg::ST_EV_DIFF: begin
                    diff_reg <= (pred_reg >= actual) ? pred_reg - actual : actual - pred_reg;
                end
                mbre_pkg::ST_EV_MUL: sq_reg <= diff_reg * diff_reg;
                mbre_pkg::ST_EV_ACC: begin
                    sq_sum_reg <= sq_sum_reg + SQ_W'(sq_reg);
                    idx_reg    <= idx_inc;
                end
                mbre_pkg::ST_SQRT: begin
                    if (sqrt_done) begin
                        res_rmse_reg <= mbre_pkg::RMSE_W'(sqrt_root);
                        res_cnt_reg  <= mbre_pkg::TCNT_W'(fill_reg);
                        res_stat_reg <= ovf_reg ? mbre_pkg::STAT_DROPPED : mbre_pkg::STAT_OK;
                    end
                end
                mbre_pkg::ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_cnt_reg, res_rmse_reg};
                        m_tuser_reg  <= res_stat_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `MBRE_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, 32'(fill_reg) <= TEST_SLOTS)
    `MBRE_ASSERT_IMP(a_gcount_bound, aclk, aresetn, 1'b1, 32'(gcount_reg) <= TRAIN_MAX)
    `MBRE_ASSERT_IMP(a_div_free, aclk, aresetn, div_start, !div_busy)
    `MBRE_ASSERT_NXT(a_train_rmw, aclk, aresetn, s_acc && in_kind == mbre_pkg::KIND_TRAIN && train_ok, state_reg == mbre_pkg::ST_TRAIN_WR)
endmodule

/* hw/rtl/mbre_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by all means and the mean square.
module mbre_div #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int DC_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [DC_W-1:0]  cnt_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] trial;

    assign rem_sh = {rem_reg, q_reg[DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DC_W'(DVD_W);
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (trial[DVS_W+1]) begin
                    rem_reg <= rem_sh[DVS_W-1:0];
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b0};
                end else begin
                    rem_reg <= trial[DVS_W-1:0];
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - DC_W'(1);
                if (cnt_reg == DC_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

/* hw/rtl/mbre_isqrt.sv */
// Digit-by-digit integer square root (floor), one root bit per cycle.
// Depends on mbre_pkg for the operand widths.
module mbre_isqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [mbre_pkg::MS_W-1:0] value,
    output logic                     done,
    output logic [mbre_pkg::RT_W-1:0] root
);
    localparam int RW   = mbre_pkg::RT_W;
    localparam int SC_W = $clog2(RW + 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [SC_W-1:0]           cnt_reg;
    logic [mbre_pkg::MS_W-1:0] src_reg;
    logic [RW+1:0]             rem_reg;
    logic [RW-1:0]             root_reg;
    logic [RW+3:0]             rem_sh;
    logic [RW+3:0]             trial;

    assign rem_sh = {rem_reg, src_reg[mbre_pkg::MS_W-1 -: 2]};
    assign trial  = (RW+4)'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SC_W'(RW);
                src_reg  <= value;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                src_reg <= {src_reg[mbre_pkg::MS_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= (RW+2)'(rem_sh - trial);
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= (RW+2)'(rem_sh);
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - SC_W'(1);
                if (cnt_reg == SC_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* hw/rtl/mbre_tables.sv */
// Per-user and per-movie sum/count memories plus the movie seen marks.
// Depends on mbre_pkg (tbl_ctl_t); reads are registered.
module mbre_tables #(
    parameter int USER_SLOTS  = 1024,
    parameter int MOVIE_SLOTS = 2048,
    parameter int SUM_W       = 21,
    parameter int CNT_W       = 18,
    parameter int UA_W        = $clog2(USER_SLOTS),
    parameter int MA_W        = $clog2(MOVIE_SLOTS)
) (
    input  logic                aclk,
    input  mbre_pkg::tbl_ctl_t  ctl,
    input  logic [UA_W-1:0]     u_addr,
    input  logic [MA_W-1:0]     m_addr,
    input  logic [SUM_W-1:0]    u_sum_wr,
    input  logic [CNT_W-1:0]    u_cnt_wr,
    input  logic [SUM_W-1:0]    m_sum_wr,
    input  logic [CNT_W-1:0]    m_cnt_wr,
    output logic [SUM_W-1:0]    u_sum_rd,
    output logic [CNT_W-1:0]    u_cnt_rd,
    output logic [SUM_W-1:0]    m_sum_rd,
    output logic [CNT_W-1:0]    m_cnt_rd,
    output logic                seen_rd
);
    logic [SUM_W+CNT_W-1:0] user_mem  [USER_SLOTS];
    logic [SUM_W+CNT_W-1:0] movie_mem [MOVIE_SLOTS];
    logic                   seen_mem  [MOVIE_SLOTS];

    logic [SUM_W+CNT_W-1:0] u_rd_reg;
    logic [SUM_W+CNT_W-1:0] m_rd_reg;
    logic                   s_rd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.user_we) begin
            user_mem[u_addr] <= {u_sum_wr, u_cnt_wr};
        end
        u_rd_reg <= user_mem[u_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.movie_we) begin
            movie_mem[m_addr] <= {m_sum_wr, m_cnt_wr};
        end
        m_rd_reg <= movie_mem[m_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.seen_we) begin
            seen_mem[m_addr] <= ctl.seen_val;
        end
        s_rd_reg <= seen_mem[m_addr];
    end

    assign u_sum_rd = u_rd_reg[SUM_W+CNT_W-1:CNT_W];
    assign u_cnt_rd = u_rd_reg[CNT_W-1:0];
    assign m_sum_rd = m_rd_reg[SUM_W+CNT_W-1:CNT_W];
    assign m_cnt_rd = m_rd_reg[CNT_W-1:0];
    assign seen_rd  = s_rd_reg;
endmodule

/* hw/rtl/mbre_tstore.sv */
// Test rating buffer: {user, movie, rating} entries, one write and one read port.
// Depends on mbre_pkg for the entry width; read data is registered.
module mbre_tstore #(
    parameter int TEST_SLOTS = 32768,
    parameter int TA_W       = $clog2(TEST_SLOTS)
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [TA_W-1:0]              wr_addr,
    input  logic [mbre_pkg::ENTRY_W-1:0] wr_data,
    input  logic [TA_W-1:0]              rd_addr,
    output logic [mbre_pkg::ENTRY_W-1:0] rd_data
);
    logic [mbre_pkg::ENTRY_W-1:0] mem [TEST_SLOTS];
    logic [mbre_pkg::ENTRY_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule

/* verif/mean_baseline_rmse_evaluator_tb.sv */
// Self-checking testbench for mean_baseline_rmse_evaluator: drives rating beats,
// predicts every report with its own mean/RMSE model and compares field by field.
// Depends on mbre_pkg and the evaluator RTL only.
`timescale 1ns / 100ps

module mean_baseline_rmse_evaluator_tb;

    localparam int USERS     = 1024;
    localparam int MOVIES    = 2048;
    localparam int TRAIN_CAP = 131072;
    localparam int TEST_CAP  = 32768;
    localparam int FRAC      = 12;
    // clear pass after reset / clear beat, plus margin
    localparam int CLEAR_WAIT = 2200;

    typedef struct packed {
        logic [mbre_pkg::RMSE_W-1:0] rmse;
        logic [mbre_pkg::TCNT_W-1:0] tested;
        logic [mbre_pkg::STAT_W-1:0] status;
    } report_t;

    typedef struct packed {
        logic [mbre_pkg::UID_W-1:0] user;
        logic [mbre_pkg::MID_W-1:0] movie;
        logic [mbre_pkg::RAT_W-1:0] rating;
    } rating_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // user_id[9:0], movie_id[20:10], rating[23:21]
    logic [1:0]  s_tuser = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // rmse[15:0], tested_count[31:16]
    logic [1:0]  m_tuser;        // status[1:0]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = '0; // predict_mode[1:0]

    mean_baseline_rmse_evaluator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    int unsigned   user_sum [USERS];
    int unsigned   user_cnt [USERS];
    int unsigned   movie_sum[MOVIES];
    int unsigned   movie_cnt[MOVIES];
    int unsigned   total_sum, total_cnt;
    rating_entry_t test_buf[$];
    bit            dropped;
    logic [mbre_pkg::MODE_W-1:0] cur_mode;

    report_t pending_reports[$];
    int      errors, beats_sent, reports_seen, hold_request;
    bit      quiet_sender, quiet_receiver;
    int      mode_hits[4];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint unsigned fx_mean(longint unsigned s, longint unsigned c);
        return (s << FRAC) / c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_tables();
        foreach (user_sum[i]) begin user_sum[i] = 0; user_cnt[i] = 0; end
        foreach (movie_sum[i]) begin movie_sum[i] = 0; movie_cnt[i] = 0; end
        total_sum = 0;
        total_cnt = 0;
        test_buf.delete();
        dropped = 0;
    endfunction

    function automatic report_t score_tests();
        report_t rep;
        longint unsigned gmean, fallback, fs, fc, pred, actual, diff, sq, ms;
        bit seen[int];
        int n;
        logic [1:0] md;
        md = cur_mode;
        n = test_buf.size();
        rep = '0;
        if (total_cnt == 0 || n == 0) begin
            rep.status = (total_cnt == 0) ? mbre_pkg::STAT_NO_TRAIN : mbre_pkg::STAT_NO_TEST;
            return rep;
        end
        gmean = fx_mean(total_sum, total_cnt);
        fallback = gmean;
        if (md == mbre_pkg::MODE_MOVIE) begin
            fs = 0;
            fc = 0;
            foreach (test_buf[i]) begin
                if (!seen.exists(test_buf[i].movie)) begin
                    seen[test_buf[i].movie] = 1;
                    fs += movie_sum[test_buf[i].movie];
                    fc += movie_cnt[test_buf[i].movie];
                end
            end
            if (fc != 0) fallback = fx_mean(fs, fc);
        end
        sq = 0;
        foreach (test_buf[i]) begin
            pred = gmean;
            actual = longint'(test_buf[i].rating) << FRAC;
            if (md == mbre_pkg::MODE_USER) begin
                if (user_cnt[test_buf[i].user] != 0)
                    pred = fx_mean(user_sum[test_buf[i].user], user_cnt[test_buf[i].user]);
            end else if (md == mbre_pkg::MODE_MOVIE) begin
                pred = (movie_cnt[test_buf[i].movie] != 0)
                     ? fx_mean(movie_sum[test_buf[i].movie], movie_cnt[test_buf[i].movie])
                     : fallback;
            end
            diff = (pred >= actual) ? pred - actual : actual - pred;
            sq += diff * diff;
        end
        ms = sq / n;   // output and mean fraction widths match: no rescale
        rep.rmse = mbre_pkg::RMSE_W'(int_sqrt(ms));
        rep.tested = mbre_pkg::TCNT_W'(n);
        rep.status = dropped ? mbre_pkg::STAT_DROPPED : mbre_pkg::STAT_OK;
        return rep;
    endfunction

    function automatic void apply_beat(mbre_pkg::kind_t k, logic [9:0] u, logic [10:0] m,
                                       logic [2:0] r);
        rating_entry_t e;
        case (k)
            mbre_pkg::KIND_TRAIN: begin
                if (total_cnt >= TRAIN_CAP) begin
                    dropped = 1;
                end else begin
                    user_sum[u] += r;  user_cnt[u]++;
                    movie_sum[m] += r; movie_cnt[m]++;
                    total_sum += r;    total_cnt++;
                end
            end
            mbre_pkg::KIND_TEST: begin
                if (test_buf.size() >= TEST_CAP) begin
                    dropped = 1;
                end else begin
                    e.user = u; e.movie = m; e.rating = r;
                    test_buf.push_back(e);
                end
            end
            mbre_pkg::KIND_FINISH: begin
                pending_reports.push_back(score_tests());
                mode_hits[cur_mode]++;
            end
            default: clear_tables();
        endcase
    endfunction

    // Valid stays high after a beat; the next call lowers it only for a gap.
    task automatic send_beat(mbre_pkg::kind_t k, logic [9:0] u, logic [10:0] m,
                             logic [2:0] r);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {r, m, u};
        do @(posedge aclk); while (!s_tready);
        apply_beat(k, u, m, r);
        beats_sent++;
    endtask

    // Drain all reports, then cover a clear pass that may still be running.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (CLEAR_WAIT) @(posedge aclk);
    endtask

    task automatic write_mode(logic [1:0] md);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= md;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_mode = md;
    endtask

    task automatic send_train(int upool, int mpool, bit wide);
        send_beat(mbre_pkg::KIND_TRAIN,
                  wide ? 10'($urandom_range(0, USERS-1)) : 10'($urandom_range(0, upool)),
                  wide ? 11'($urandom_range(0, MOVIES-1)) : 11'($urandom_range(0, mpool)),
                  wide ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5)));
    endtask

    task automatic send_test(int upool, int mpool, bit wide);
        send_beat(mbre_pkg::KIND_TEST,
                  wide ? 10'($urandom_range(0, USERS-1)) : 10'($urandom_range(0, upool + 2)),
                  wide ? 11'($urandom_range(0, MOVIES-1)) : 11'($urandom_range(0, mpool + 2)),
                  wide ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5)));
    endtask

    task automatic test_directed();
        // nothing trained, nothing buffered
        send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
        send_beat(mbre_pkg::KIND_TRAIN, 10'd0, 11'd0, 3'd7);
        send_beat(mbre_pkg::KIND_TRAIN, 10'd1023, 11'd2047, 3'd0);
        send_beat(mbre_pkg::KIND_TRAIN, 10'd5, 11'd9, 3'd4);
        // trained but no tests
        send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
        send_beat(mbre_pkg::KIND_TEST, 10'd0, 11'd2047, 3'd7);
        send_beat(mbre_pkg::KIND_TEST, 10'd1023, 11'd0, 3'd0);
        send_beat(mbre_pkg::KIND_TEST, 10'd700, 11'd9, 3'd3);     // unrated user
        send_beat(mbre_pkg::KIND_TEST, 10'd5, 11'd1500, 3'd5);    // unrated movie -> fallback
        for (int md = 0; md < 4; md++) begin
            write_mode(md[1:0]);
            send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
        end
        // only unrated test movies: fallback drops to the global mean
        send_beat(mbre_pkg::KIND_CLEAR, 0, 0, 0);
        send_beat(mbre_pkg::KIND_TRAIN, 10'd3, 11'd40, 3'd2);
        send_beat(mbre_pkg::KIND_TEST, 10'd3, 11'd41, 3'd5);
        send_beat(mbre_pkg::KIND_TEST, 10'd4, 11'd42, 3'd1);
        write_mode(mbre_pkg::MODE_MOVIE);
        send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
        send_beat(mbre_pkg::KIND_CLEAR, 0, 0, 0);
        send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
    endtask

    task automatic test_random_rounds(int beat_goal);
        int upool, mpool, ntrain, ntest;
        logic [1:0] mode_seq[6] = '{mbre_pkg::MODE_USER, mbre_pkg::MODE_MOVIE,
                                    mbre_pkg::MODE_GLOBAL, 2'd3, mbre_pkg::MODE_MOVIE,
                                    mbre_pkg::MODE_USER};
        int round;
        round = 0;
        while (beats_sent < beat_goal) begin
            write_mode(mode_seq[round % 6]);
            quiet_sender   = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            if (test_buf.size() > 50 || $urandom_range(0, 2) == 0)
                send_beat(mbre_pkg::KIND_CLEAR, 0, 0, 0);
            upool  = $urandom_range(3, 20);
            mpool  = $urandom_range(3, 20);
            ntrain = $urandom_range(5, 40);
            ntest  = $urandom_range(1, 15);
            for (int i = 0; i < ntrain; i++) begin
                send_train(upool, mpool, $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 4) == 0) send_test(upool, mpool, $urandom_range(0, 9) == 0);
            end
            for (int i = 0; i < ntest; i++) send_test(upool, mpool, $urandom_range(0, 9) == 0);
            send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
            // noise: a stray train, test or finish beat, never a clear
            if ($urandom_range(0, 3) == 0) begin
                send_beat(mbre_pkg::kind_t'($urandom_range(0, 2)), 10'($urandom),
                          11'($urandom), 3'($urandom));
                send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
            end
            round++;
        end
        quiet_sender = 0;
        quiet_receiver = 0;
    endtask

    task automatic test_backpressure();
        write_mode(mbre_pkg::MODE_USER);
        send_beat(mbre_pkg::KIND_CLEAR, 0, 0, 0);
        hold_request = 3000;
        quiet_sender = 1;
        for (int i = 0; i < 6; i++) begin
            send_train(7, 7, 0);
            send_test(7, 7, 0);
            send_beat(mbre_pkg::KIND_FINISH, 0, 0, 0);
        end
        quiet_sender = 0;
    endtask

    // result side: random stalls, or a long counted hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                report_t got, want;
                got.rmse   = m_tdata[15:0];
                got.tested = m_tdata[31:16];
                got.status = m_tuser;
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected report rmse=%h count=%0d status=%0d",
                             $time, got.rmse, got.tested, got.status);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.rmse !== want.rmse) begin
                        errors++;
                        $display("%0t: rmse expected %h actual %h", $time, want.rmse, got.rmse);
                    end
                    if (got.tested !== want.tested) begin
                        errors++;
                        $display("%0t: tested_count expected %0d actual %0d", $time,
                                 want.tested, got.tested);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    end
                end
            end
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (!quiet_receiver && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                stall = pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #200ms;
        $display("mean_baseline_rmse_evaluator_tb: FAIL");
        $finish;
    end

    initial begin
        int guard;
        clear_tables();
        cur_mode = mbre_pkg::MODE_GLOBAL;
        errors = 0;
        beats_sent = 0;
        reports_seen = 0;
        hold_request = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();
        test_directed();
        test_backpressure();
        test_random_rounds(1400);
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_reports.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (100) @(posedge aclk);
        if (pending_reports.size() != 0) begin
            errors++;
            $display("%0t: %0d reports never arrived", $time, pending_reports.size());
        end
        $display("Sent %0d beats, checked %0d reports; finishes per mode 0..3: %0d %0d %0d %0d",
                 beats_sent, reports_seen, mode_hits[0], mode_hits[1], mode_hits[2],
                 mode_hits[3]);
        if (errors == 0) begin
            $display("mean_baseline_rmse_evaluator_tb: PASS");
        end else begin
            $display("mean_baseline_rmse_evaluator_tb: FAIL");
        end
        $finish;
    end

endmodule
